FILE: design/brl_pkg.sv
package brl_pkg;

  // Coordinate and payload widths
  localparam int COORD_BITS    = 13;
  localparam int DELTA_W       = COORD_BITS + 1;
  localparam int ERR_W         = COORD_BITS + 3;
  localparam int COLOR_W       = 24;
  localparam int ADDR_W        = 24;
  localparam int BPP_W         = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 4;

  // Defaults handed to the top level parameters
  localparam int SCREEN_WIDTH  = 1900;
  localparam int SCREEN_HEIGHT = 1200;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0]    delta_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic [COLOR_W-1:0]           color_t;
  typedef logic [ADDR_W-1:0]            addr_t;

  typedef enum logic {
    KindLoad = 1'b0,
    KindTick = 1'b1
  } kind_e;

  // Register word index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegOffsetX = 2'd0,
    RegOffsetY = 2'd1,
    RegBpp     = 2'd2
  } reg_e;

  typedef struct packed {
    coord_t           offset_x;
    coord_t           offset_y;
    logic [BPP_W-1:0] bpp;
  } cfg_t;

  // Command passed from the front end to the stepper
  typedef struct packed {
    kind_e  kind;
    coord_t cur_x;
    coord_t cur_y;
    coord_t goal_x;
    coord_t goal_y;
    delta_t delta_x;
    delta_t neg_delta_y;
    logic   step_x_neg;
    logic   step_y_neg;
    err_t   error_term;
    color_t color;
  } cmd_t;

endpackage

FILE: design/brl_in_if.sv
interface brl_in_if;
  import brl_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t start_color;
  color_t end_color;

  modport source (
    output valid, kind, start_x, start_y, end_x, end_y, start_color, end_color,
    input  ready
  );

  modport sink (
    input  valid, kind, start_x, start_y, end_x, end_y, start_color, end_color,
    output ready
  );
endinterface

FILE: design/brl_out_if.sv
interface brl_out_if;
  import brl_pkg::*;

  logic       valid;
  logic       ready;
  addr_t      byte_address;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       write;
  logic       last;

  modport source (
    output valid, byte_address, blue, green, red, write, last,
    input  ready
  );

  modport sink (
    input  valid, byte_address, blue, green, red, write, last,
    output ready
  );
endinterface

FILE: design/bresenham_line_rasterizer.sv
// Bresenham line rasterizer.
// in_ch carries transactions of two kinds: a load gives the line endpoints
// and colours, a tick asks for the next pixel. A tick with no line in
// progress is dropped. out_ch gives one transaction per pixel: the frame
// buffer byte address, the colour bytes, a write flag for on-screen pixels
// and a last flag on the end point, after which ticks are dropped again.
// The APB port holds the pan offsets and bytes per pixel; write it only
// while no transaction is in flight.
// Path: a tick accepted on in_ch passes through the command queue, then
// the clip, linear index and address multiply stages, before it is offered
// on out_ch. Throughput: one transaction per cycle while out_ch is ready,
// as the stepper makes one error step per tick.
// A stalled out_ch holds its transaction; the pipeline fills behind it and
// the two-entry queue then drops in_ch ready, so nothing is lost.
// Reset clears the queue, the pipeline and the line in progress, and sets
// the offsets to zero and bytes per pixel to four.
module bresenham_line_rasterizer #(
  parameter int SCREEN_WIDTH  = brl_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = brl_pkg::SCREEN_HEIGHT,
  parameter int QUEUE_DEPTH   = brl_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  brl_in_if.sink                         in_ch,
  brl_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [brl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [brl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import brl_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;

  brl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  brl_front u_front (
    .in_ch       (in_ch),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  brl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  brl_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_ch      (out_ch)
  );

endmodule

FILE: design/brl_cfg.sv
module brl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brl_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [brl_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [brl_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output brl_pkg::cfg_t                  cfg_o
);
  import brl_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        RegOffsetX: cfg_d.offset_x = coord_t'(pwdata[COORD_BITS-1:0]);
        RegOffsetY: cfg_d.offset_y = coord_t'(pwdata[COORD_BITS-1:0]);
        RegBpp:     cfg_d.bpp      = pwdata[BPP_W-1:0];
        default:    cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.bpp      <= BPP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Return the addressed register, offsets sign-extended
  always_comb begin
    unique case (sel)
      RegOffsetX: prdata = {{(CFG_DATA_W-COORD_BITS){cfg_q.offset_x[COORD_BITS-1]}},
                            cfg_q.offset_x};
      RegOffsetY: prdata = {{(CFG_DATA_W-COORD_BITS){cfg_q.offset_y[COORD_BITS-1]}},
                            cfg_q.offset_y};
      RegBpp:     prdata = {{(CFG_DATA_W-BPP_W){1'b0}}, cfg_q.bpp};
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: design/brl_front.sv
module brl_front (
  brl_in_if.sink        in_ch,
  output brl_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import brl_pkg::*;

  delta_t ddx, ddy;
  delta_t abs_dx, neg_abs_dy;
  color_t c0, c1;

  assign in_ch.ready = cmd_ready_i;
  assign cmd_valid_o = in_ch.valid;

  // Work out the stepper set-up for a load
  always_comb begin
    ddx = {in_ch.end_x[COORD_BITS-1], in_ch.end_x} -
          {in_ch.start_x[COORD_BITS-1], in_ch.start_x};
    ddy = {in_ch.end_y[COORD_BITS-1], in_ch.end_y} -
          {in_ch.start_y[COORD_BITS-1], in_ch.start_y};
    abs_dx     = ddx[DELTA_W-1] ? -ddx : ddx;
    neg_abs_dy = ddy[DELTA_W-1] ? ddy : -ddy;
    c0 = in_ch.start_color;
    c1 = in_ch.end_color;

    cmd_o.kind        = kind_e'(in_ch.kind);
    cmd_o.cur_x       = in_ch.start_x;
    cmd_o.cur_y       = in_ch.start_y;
    cmd_o.goal_x      = in_ch.end_x;
    cmd_o.goal_y      = in_ch.end_y;
    cmd_o.delta_x     = abs_dx;
    cmd_o.neg_delta_y = neg_abs_dy;
    cmd_o.step_x_neg  = !(in_ch.start_x < in_ch.end_x);
    cmd_o.step_y_neg  = !(in_ch.start_y < in_ch.end_y);
    cmd_o.error_term  = {{(ERR_W-DELTA_W){abs_dx[DELTA_W-1]}}, abs_dx} +
                        {{(ERR_W-DELTA_W){neg_abs_dy[DELTA_W-1]}}, neg_abs_dy};
    // Take the end colour when the colours differ and start green is set
    cmd_o.color = ((c0 != c1) && (c0[15:8] != 8'd0)) ? c1 : c0;
  end

endmodule

FILE: design/brl_queue.sv
module brl_queue #(
  parameter int DEPTH = brl_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  brl_pkg::cmd_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output brl_pkg::cmd_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import brl_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: design/brl_back.sv
module brl_back #(
  parameter int SCREEN_WIDTH  = brl_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = brl_pkg::SCREEN_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  brl_pkg::cfg_t cfg_i,
  input  brl_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  brl_out_if.source     out_ch
);
  import brl_pkg::*;

  localparam int XW = $clog2(SCREEN_WIDTH + 1);
  localparam int YW = $clog2(SCREEN_HEIGHT + 1);
  localparam logic signed [COORD_BITS+1:0] WidthS  = (COORD_BITS + 2)'(SCREEN_WIDTH);
  localparam logic signed [COORD_BITS+1:0] HeightS = (COORD_BITS + 2)'(SCREEN_HEIGHT);
  localparam addr_t WidthA = ADDR_W'(SCREEN_WIDTH);

  // Stepper state
  logic   busy_q, busy_d;
  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  delta_t dx_q, dx_d, ndy_q, ndy_d;
  logic   sxn_q, sxn_d, syn_q, syn_d;
  err_t   err_q, err_d;
  color_t color_q, color_d;

  // Pipeline registers
  logic          s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d;
  logic          s1_on_q, s1_last_q, s2_on_q, s2_last_q;
  logic [XW-1:0] s1_px_q;
  logic [YW-1:0] s1_py_q;
  color_t        s1_color_q, s2_color_q, s3_color_q;
  addr_t         s2_lin_q, s3_addr_q;
  logic          s3_on_q, s3_last_q;

  logic en1, en2, en3, pop, emit, at_end, x_step, y_step;
  logic signed [COORD_BITS:0]   px, py;
  logic signed [COORD_BITS+1:0] pxe, pye;
  logic signed [ERR_W:0]        e2, ndy_e, dx_e;
  err_t                         ndy_err, dx_err;
  logic                         on_screen;
  logic [ADDR_W+BPP_W-1:0]      prod;

  // Let each stage move when the next one is free or moving
  assign en3 = !s3_v_q | out_ch.ready;
  assign en2 = !s2_v_q | en3;
  assign en1 = !s1_v_q | en2;
  assign cmd_ready_o = en1;
  assign pop  = cmd_valid_i & en1;
  assign emit = pop & (cmd_i.kind == KindTick) & busy_q;

  // Pan and clip the current pixel
  always_comb begin
    px  = {cur_x_q[COORD_BITS-1], cur_x_q} + {cfg_i.offset_x[COORD_BITS-1], cfg_i.offset_x};
    py  = {cur_y_q[COORD_BITS-1], cur_y_q} + {cfg_i.offset_y[COORD_BITS-1], cfg_i.offset_y};
    pxe = {px[COORD_BITS], px};
    pye = {py[COORD_BITS], py};
    on_screen = !px[COORD_BITS] && (pxe < WidthS) && !py[COORD_BITS] && (pye < HeightS);
    at_end    = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
  end

  // Bresenham error step
  always_comb begin
    e2      = {err_q, 1'b0};
    ndy_e   = {{(ERR_W-DELTA_W+1){ndy_q[DELTA_W-1]}}, ndy_q};
    dx_e    = {{(ERR_W-DELTA_W+1){dx_q[DELTA_W-1]}}, dx_q};
    ndy_err = {{(ERR_W-DELTA_W){ndy_q[DELTA_W-1]}}, ndy_q};
    dx_err  = {{(ERR_W-DELTA_W){dx_q[DELTA_W-1]}}, dx_q};
    x_step  = (e2 >= ndy_e);
    y_step  = (e2 <= dx_e);
  end

  // Load a new line or advance the current one
  always_comb begin
    busy_d   = busy_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    goal_x_d = goal_x_q;
    goal_y_d = goal_y_q;
    dx_d     = dx_q;
    ndy_d    = ndy_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    err_d    = err_q;
    color_d  = color_q;
    if (pop && cmd_i.kind == KindLoad) begin
      busy_d   = 1'b1;
      cur_x_d  = cmd_i.cur_x;
      cur_y_d  = cmd_i.cur_y;
      goal_x_d = cmd_i.goal_x;
      goal_y_d = cmd_i.goal_y;
      dx_d     = cmd_i.delta_x;
      ndy_d    = cmd_i.neg_delta_y;
      sxn_d    = cmd_i.step_x_neg;
      syn_d    = cmd_i.step_y_neg;
      err_d    = cmd_i.error_term;
      color_d  = cmd_i.color;
    end else if (emit) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        err_d = err_q + (x_step ? ndy_err : '0) + (y_step ? dx_err : '0);
        if (x_step) begin
          cur_x_d = sxn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
        end
        if (y_step) begin
          cur_y_d = syn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      goal_x_q <= '0;
      goal_y_q <= '0;
      dx_q     <= '0;
      ndy_q    <= '0;
      sxn_q    <= 1'b0;
      syn_q    <= 1'b0;
      err_q    <= '0;
      color_q  <= '0;
    end else begin
      busy_q   <= busy_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      goal_x_q <= goal_x_d;
      goal_y_q <= goal_y_d;
      dx_q     <= dx_d;
      ndy_q    <= ndy_d;
      sxn_q    <= sxn_d;
      syn_q    <= syn_d;
      err_q    <= err_d;
      color_q  <= color_d;
    end
  end

  // Stage valid bits
  always_comb begin
    s1_v_d = en1 ? emit   : s1_v_q;
    s2_v_d = en2 ? s1_v_q : s2_v_q;
    s3_v_d = en3 ? s2_v_q : s3_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
    end
  end

  assign prod = (ADDR_W + BPP_W)'(cfg_i.bpp) * (ADDR_W + BPP_W)'(s2_lin_q);

  // Pixel pipeline: clip, linear index, byte address
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_on_q    <= on_screen;
      s1_last_q  <= at_end;
      s1_px_q    <= px[XW-1:0];
      s1_py_q    <= py[YW-1:0];
      s1_color_q <= color_q;
    end
    if (en2) begin
      s2_on_q    <= s1_on_q;
      s2_last_q  <= s1_last_q;
      s2_color_q <= s1_color_q;
      s2_lin_q   <= s1_on_q ? ADDR_W'(s1_px_q) + ADDR_W'(s1_py_q) * WidthA : '0;
    end
    if (en3) begin
      s3_on_q    <= s2_on_q;
      s3_last_q  <= s2_last_q;
      s3_color_q <= s2_color_q;
      s3_addr_q  <= prod[ADDR_W-1:0];
    end
  end

  assign out_ch.valid        = s3_v_q;
  assign out_ch.byte_address = s3_addr_q;
  assign out_ch.blue         = s3_color_q[7:0];
  assign out_ch.green        = s3_color_q[15:8];
  assign out_ch.red          = s3_color_q[23:16];
  assign out_ch.write        = s3_on_q;
  assign out_ch.last         = s3_last_q;

endmodule
